FILE: rtl/ssf_pkg.sv
package ssf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int IW_W = 11;
  localparam int EW = (ADDR_W + 1 > IW_W) ? ADDR_W + 1 : IW_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int ODEPTH = 4;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = $clog2(ODEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = IW_W;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b1;

  localparam logic [1:0] MODE_SOBEL   = 2'd0;
  localparam logic [1:0] MODE_SHARPEN = 2'd1;

  typedef logic [8:0][7:0] win_t;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
    logic       first;
    logic       emit_mid;
    logic       emit_last;
    logic       drain;
  } item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              nonempty;
  } q_stat_t;

  function automatic logic signed [12:0] ext(input logic [7:0] x);
    return $signed({5'b0, x});
  endfunction

  function automatic logic [7:0] filter_px(input logic [1:0] mode, input win_t w);
    logic signed [12:0] v;
    logic [7:0] r;
    case (mode)
      MODE_SOBEL: begin
        v = (ext(w[0]) - ext(w[6])) + ((ext(w[1]) - ext(w[7])) <<< 1) +
            (ext(w[2]) - ext(w[8])) + 13'sd127;
      end
      MODE_SHARPEN: begin
        v = (ext(w[4]) * 13'sd9) - ext(w[0]) - ext(w[3]) - ext(w[6]) - ext(w[1]) -
            ext(w[7]) - ext(w[2]) - ext(w[5]) - ext(w[8]);
      end
      default: v = 13'sd0;
    endcase
    if (v < 13'sd0) begin
      r = 8'd0;
    end else if (v > 13'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/ssf_front.sv
module ssf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         command,
  input  logic [7:0]                   pixel_in,
  input  logic [ssf_pkg::IW_W-1:0]     image_width,
  input  ssf_pkg::q_stat_t             q_stat,
  output logic                         q_push,
  output ssf_pkg::item_t               q_item
);

  typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_LATER} phase_t;

  phase_t                      phase;
  logic [ssf_pkg::ADDR_W-1:0]  col;

  logic [15:0] mem [ssf_pkg::MAX_WIDTH];
  logic [15:0] mem_rd;
  logic [15:0] fwd_data;
  logic        fwd;
  logic [15:0] entry;

  logic                        s1_valid;
  logic [ssf_pkg::ADDR_W-1:0]  s1_addr;
  logic [7:0]                  s1_px;
  logic                        s1_first;
  logic                        s1_emit_mid;
  logic                        s1_emit_last;
  logic                        s1_drain;
  logic                        s1_top_en;
  logic                        s1_mid_en;

  logic                        accept;
  logic                        drain;
  logic                        last;
  logic [7:0]                  px;
  logic [ssf_pkg::EW-1:0]      w_ext;
  logic [ssf_pkg::EW-1:0]      w_eff;
  logic [ssf_pkg::EW-1:0]      col_ext;

  assign full = s1_valid ? (q_stat.count >= ssf_pkg::QCNT_W'(ssf_pkg::QDEPTH - 1))
                         : (q_stat.count >= ssf_pkg::QCNT_W'(ssf_pkg::QDEPTH));
  assign accept = push && !full;
  assign drain = command;
  assign px = drain ? 8'd0 : pixel_in;

  always_comb begin
    w_ext = ssf_pkg::EW'(image_width);
    if (w_ext == '0) begin
      w_eff = ssf_pkg::EW'(1);
    end else if (w_ext > ssf_pkg::EW'(ssf_pkg::MAX_WIDTH)) begin
      w_eff = ssf_pkg::EW'(ssf_pkg::MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    col_ext = ssf_pkg::EW'(col);
    last = (col_ext + ssf_pkg::EW'(1)) >= w_eff;
  end

  // The store entry holds the row above in the upper byte, two rows above below it.
  assign entry = fwd ? fwd_data : mem_rd;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_rd <= mem[col];
      fwd_data <= {s1_px, entry[15:8]};
      s1_addr <= col;
      s1_px <= px;
      s1_first <= (col == '0);
      s1_emit_mid <= (phase != PH_FIRST) && (col != '0);
      s1_emit_last <= (phase != PH_FIRST) && last;
      s1_drain <= drain;
      s1_top_en <= (phase == PH_LATER);
      s1_mid_en <= (phase != PH_FIRST);
    end
    if (s1_valid) begin
      mem[s1_addr] <= {s1_px, entry[15:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      col <= '0;
      s1_valid <= 1'b0;
      fwd <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        fwd <= s1_valid && (s1_addr == col);
        if (last) begin
          col <= '0;
          if (drain) begin
            phase <= PH_FIRST;
          end else begin
            unique case (phase)
              PH_FIRST:  phase <= PH_SECOND;
              PH_SECOND: phase <= PH_LATER;
              PH_LATER:  phase <= PH_LATER;
              default:   phase <= PH_FIRST;
            endcase
          end
        end else begin
          col <= col + ssf_pkg::ADDR_W'(1);
        end
      end
    end
  end

  assign q_push = s1_valid;

  always_comb begin
    q_item.top = s1_top_en ? entry[7:0] : 8'd0;
    q_item.mid = s1_mid_en ? entry[15:8] : 8'd0;
    q_item.bot = s1_px;
    q_item.first = s1_first;
    q_item.emit_mid = s1_emit_mid;
    q_item.emit_last = s1_emit_last;
    q_item.drain = s1_drain;
  end

endmodule

FILE: rtl/ssf_queue.sv
module ssf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_push,
  input  ssf_pkg::item_t   q_item,
  input  logic             q_pop,
  output ssf_pkg::item_t   q_head,
  output ssf_pkg::q_stat_t q_stat
);

  ssf_pkg::item_t              slots [ssf_pkg::QDEPTH];
  logic [ssf_pkg::QPTR_W-1:0]  rd_ptr;
  logic [ssf_pkg::QPTR_W-1:0]  wr_ptr;
  logic [ssf_pkg::QCNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (q_push) begin
      slots[wr_ptr] <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= wr_ptr + ssf_pkg::QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + ssf_pkg::QPTR_W'(1);
      end
      if (q_push && !q_pop) begin
        count <= count + ssf_pkg::QCNT_W'(1);
      end else if (!q_push && q_pop) begin
        count <= count - ssf_pkg::QCNT_W'(1);
      end
    end
  end

  assign q_head = slots[rd_ptr];
  assign q_stat.count = count;
  assign q_stat.nonempty = (count != '0);

endmodule

FILE: rtl/ssf_back.sv
module ssf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ssf_pkg::item_t       q_head,
  input  ssf_pkg::q_stat_t     q_stat,
  output logic                 q_pop,
  input  logic [1:0]           filter_mode,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           pixel_out,
  output logic                 row_end,
  output logic                 frame_end
);

  typedef struct packed {
    logic [7:0] px;
    logic       re;
    logic       fe;
  } res_t;

  ssf_pkg::win_t               window;
  ssf_pkg::win_t               base;
  ssf_pkg::win_t               cand;
  logic                        tail;
  logic                        tail_drain;

  res_t                        ofifo [ssf_pkg::ODEPTH];
  logic [ssf_pkg::OPTR_W-1:0]  o_rd;
  logic [ssf_pkg::OPTR_W-1:0]  o_wr;
  logic [ssf_pkg::OCNT_W-1:0]  o_cnt;

  logic                        out_pop;
  logic                        room;
  logic                        take;
  logic                        tail_go;
  logic                        o_push;
  res_t                        o_data;

  assign empty = (o_cnt == '0);
  assign out_pop = pop && !empty;
  assign room = (o_cnt < ssf_pkg::OCNT_W'(ssf_pkg::ODEPTH)) || out_pop;
  assign take = q_stat.nonempty && !tail && room;
  assign tail_go = tail && room;
  assign q_pop = take;

  // A new column enters on the right; the row end beat shifts in a zero column.
  always_comb begin
    base = (take && q_head.first) ? '0 : window;
    cand[5:0] = base[8:3];
    if (take) begin
      cand[6] = q_head.top;
      cand[7] = q_head.mid;
      cand[8] = q_head.bot;
    end else begin
      cand[6] = 8'd0;
      cand[7] = 8'd0;
      cand[8] = 8'd0;
    end
    o_push = (take && q_head.emit_mid) || tail_go;
    o_data.px = ssf_pkg::filter_px(filter_mode, cand);
    o_data.re = tail_go;
    o_data.fe = tail_go && tail_drain;
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      ofifo[o_wr] <= o_data;
    end
    if (take) begin
      tail_drain <= q_head.drain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      tail <= 1'b0;
      o_rd <= '0;
      o_wr <= '0;
      o_cnt <= '0;
    end else begin
      if (take || tail_go) begin
        window <= cand;
      end
      if (take) begin
        tail <= q_head.emit_last;
      end else if (tail_go) begin
        tail <= 1'b0;
      end
      if (o_push) begin
        o_wr <= o_wr + ssf_pkg::OPTR_W'(1);
      end
      if (out_pop) begin
        o_rd <= o_rd + ssf_pkg::OPTR_W'(1);
      end
      if (o_push && !out_pop) begin
        o_cnt <= o_cnt + ssf_pkg::OCNT_W'(1);
      end else if (!o_push && out_pop) begin
        o_cnt <= o_cnt - ssf_pkg::OCNT_W'(1);
      end
    end
  end

  assign pixel_out = ofifo[o_rd].px;
  assign row_end = ofifo[o_rd].re;
  assign frame_end = ofifo[o_rd].fe;

endmodule

FILE: rtl/image_3x3_sobel_sharpen_filter.sv
// Path: an accepted beat passes the front stage register, then the item queue write, then the
// window update into the output queue before its first result is on the result ports; a row
// end result follows from an extra window step, so a one-pixel row gives only its row end result.
// Throughput: one pixel per cycle while full stays low; the window unit spends an extra step on
// each row end beat that gives results, which lowers the sustained rate.
// Reset is synchronous: counters, window, queue pointers and configuration registers clear; line stores keep data.
module image_3x3_sobel_sharpen_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            command,
  input  logic [7:0]                      pixel_in,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      pixel_out,
  output logic                            row_end,
  output logic                            frame_end,
  input  logic                            cfg_write,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [1:0]                  filter_mode;
  logic [ssf_pkg::IW_W-1:0]    image_width;

  ssf_pkg::q_stat_t            q_stat;
  ssf_pkg::item_t              q_item;
  ssf_pkg::item_t              q_head;
  logic                        q_push;
  logic                        q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= ssf_pkg::MODE_SOBEL;
      image_width <= ssf_pkg::IW_W'(1024);
    end else if (cfg_write) begin
      unique case (cfg_index)
        ssf_pkg::REG_FILTER_MODE: filter_mode <= cfg_data[1:0];
        ssf_pkg::REG_IMAGE_WIDTH: image_width <= cfg_data;
        default: ;
      endcase
    end
  end

  ssf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .pixel_in    (pixel_in),
    .image_width (image_width),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  ssf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .q_item (q_item),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  ssf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_stat      (q_stat),
    .q_pop       (q_pop),
    .filter_mode (filter_mode),
    .empty       (empty),
    .pop         (pop),
    .pixel_out   (pixel_out),
    .row_end     (row_end),
    .frame_end   (frame_end)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= ssf_pkg::QCNT_W'(ssf_pkg::QDEPTH))
    else $error("Item queue holds more beats than its depth.");

  a_queue_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (q_stat.count == ssf_pkg::QCNT_W'(ssf_pkg::QDEPTH)) |-> full)
    else $error("Input is open while the item queue is full.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_stat.nonempty)
    else $error("Window unit took a beat from an empty item queue.");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (q_stat.count == ssf_pkg::QCNT_W'(ssf_pkg::QDEPTH)) |-> !q_push || q_pop)
    else $error("Item queue written while full.");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;
  localparam logic [1:0] MODE_BLANK = 2'd2;
  localparam logic [1:0] MODE_BLANK_HI = 2'd3;
  localparam int LINE_LEN = ssf_pkg::MAX_WIDTH;
  localparam int SETTLE = 8;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 520;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic       drain;
    logic [7:0] px;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] px;
    logic       row_end;
    logic       frame_end;
  } filt_res_t;

  typedef enum logic [1:0] {FIRST_ROW, SECOND_ROW, LATER_ROW} row_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic command = CMD_PIXEL;
  logic [7:0] pixel_in = 8'd0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] pixel_out;
  logic row_end;
  logic frame_end;
  logic cfg_write = 1'b0;
  logic [ssf_pkg::CFG_IDX_W-1:0] cfg_index = ssf_pkg::REG_FILTER_MODE;
  logic [ssf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pix_item_t pending_pixels[$];
  filt_res_t expected_filtered[$];
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic in_taken = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned hold_left = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  bit steady = 1'b0;

  logic [7:0] above_line [LINE_LEN];
  logic [7:0] above2_line [LINE_LEN];
  logic [7:0] nbhd [9] = '{default: 8'd0};
  int unsigned col_pos = 0;
  row_phase_t row_state = FIRST_ROW;
  logic [1:0] cur_mode = ssf_pkg::MODE_SOBEL;
  logic [ssf_pkg::CFG_DATA_W-1:0] cur_width = 11'd1024;

  image_3x3_sobel_sharpen_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .pixel_in  (pixel_in),
    .empty     (empty),
    .pop       (pop),
    .pixel_out (pixel_out),
    .row_end   (row_end),
    .frame_end (frame_end),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_width(input int w);
    if (w == 0) return 1;
    if (w > LINE_LEN) return LINE_LEN;
    return w;
  endfunction

  function automatic logic [7:0] rand_px();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] filtered_px();
    int p [9];
    int acc;
    foreach (p[i]) p[i] = int'(nbhd[i]);
    case (cur_mode)
      ssf_pkg::MODE_SOBEL: acc = (p[0] - p[6]) + 2 * (p[1] - p[7]) + (p[2] - p[8]) + 127;
      ssf_pkg::MODE_SHARPEN: begin
        acc = 9 * p[4] - p[0] - p[1] - p[2] - p[3] - p[5] - p[6] - p[7] - p[8];
      end
      default: acc = 0;
    endcase
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  task automatic shift_window(input logic [7:0] t, input logic [7:0] m, input logic [7:0] b);
    for (int i = 0; i < 6; i++) nbhd[i] = nbhd[i + 3];
    nbhd[6] = t;
    nbhd[7] = m;
    nbhd[8] = b;
  endtask

  task automatic clear_window();
    foreach (nbhd[i]) nbhd[i] = 8'd0;
  endtask

  task automatic filter_beat(input logic drain, input logic [7:0] px_raw);
    logic [7:0] px;
    logic [7:0] top_px;
    logic [7:0] mid_px;
    int unsigned w;
    int unsigned c;
    logic last;
    filt_res_t res;
    px = drain ? 8'd0 : px_raw;
    w = eff_width(int'(cur_width));
    c = (col_pos >= LINE_LEN) ? LINE_LEN - 1 : col_pos;
    top_px = (row_state >= LATER_ROW) ? above2_line[c] : 8'd0;
    mid_px = (row_state >= SECOND_ROW) ? above_line[c] : 8'd0;
    above2_line[c] = above_line[c];
    above_line[c] = px;
    if (c == 0) clear_window();
    shift_window(top_px, mid_px, px);
    last = (c + 1 >= w);
    if (row_state >= SECOND_ROW) begin
      if (c >= 1) begin
        res.px = filtered_px();
        res.row_end = 1'b0;
        res.frame_end = 1'b0;
        expected_filtered.insert(expected_filtered.size(), res);
      end
      if (last) begin
        shift_window(8'd0, 8'd0, 8'd0);
        res.px = filtered_px();
        res.row_end = 1'b1;
        res.frame_end = drain;
        expected_filtered.insert(expected_filtered.size(), res);
      end
    end
    if (last) begin
      col_pos = 0;
      if (drain) begin
        clear_window();
        row_state = FIRST_ROW;
      end else if (row_state == FIRST_ROW) begin
        row_state = SECOND_ROW;
      end else begin
        row_state = LATER_ROW;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin
    filt_res_t want;
    in_taken <= push && !full;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          ssf_pkg::REG_FILTER_MODE: cur_mode = cfg_data[1:0];
          ssf_pkg::REG_IMAGE_WIDTH: cur_width = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        filter_beat(command, pixel_in);
        items_accepted++;
      end
      if (pop && !empty) begin
        if (expected_filtered.size() == 0) begin
          $display("%0t: beat expected none, actual pixel_out %0d row_end %0b frame_end %0b",
                   $time, pixel_out, row_end, frame_end);
          err_cnt++;
        end else begin
          want = expected_filtered.pop_front();
          if (pixel_out !== want.px) begin
            $display("%0t: pixel_out expected %0d, actual %0d", $time, want.px, pixel_out);
            err_cnt++;
          end
          if (row_end !== want.row_end) begin
            $display("%0t: row_end expected %0b, actual %0b", $time, want.row_end, row_end);
            err_cnt++;
          end
          if (frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b, actual %0b", $time, want.frame_end,
                     frame_end);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    pix_item_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (src_gap != 0) begin
        push <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (pending_pixels.size() != 0) begin
        nxt = pending_pixels.pop_front();
        command <= nxt.drain;
        pixel_in <= nxt.px;
        push <= 1'b1;
        src_gap <= steady ? 0 : gap_len();
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      pop <= 1'b0;
      hold_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else if (sink_gap != 0) begin
      pop <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      pop <= 1'b1;
      sink_gap <= steady ? 0 : gap_len();
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_item(input logic drain, input logic [7:0] px);
    pix_item_t it;
    it.drain = drain;
    it.px = px;
    pending_pixels.insert(pending_pixels.size(), it);
    items_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (items_accepted != items_queued || expected_filtered.size() != 0);
    repeat (SETTLE) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_reg(input logic [ssf_pkg::CFG_IDX_W-1:0] idx,
                         input logic [ssf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int width_pick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 70) return $urandom_range(1, 8);
    if (r < 92) return $urandom_range(9, 40);
    return $urandom_range(41, 160);
  endfunction

  task automatic random_frame();
    int w;
    int nrows;
    int row;
    int col;
    int cut_row;
    int cut_col;
    bit cut_armed;
    bit last;
    bit drain;
    wait_idle();
    steady = ($urandom_range(0, 9) == 0);
    w = width_pick();
    set_reg(ssf_pkg::REG_IMAGE_WIDTH, ssf_pkg::CFG_DATA_W'(w));
    if ($urandom_range(0, 1) == 1) begin
      set_reg(ssf_pkg::REG_FILTER_MODE, ssf_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
    end
    nrows = $urandom_range(0, 4);
    cut_armed = ($urandom_range(0, 5) == 0);
    cut_row = $urandom_range(0, nrows);
    cut_col = $urandom_range(0, eff_width(w) - 1);
    row = 0;
    col = 0;
    do begin
      // Registers change only while the block is idle, and the width never grows
      // inside a frame so that every line store entry read was written in this frame.
      if (cut_armed && row == cut_row && col == cut_col) begin
        cut_armed = 1'b0;
        wait_idle();
        if ($urandom_range(0, 1) == 1) begin
          w = $urandom_range(0, eff_width(w));
          set_reg(ssf_pkg::REG_IMAGE_WIDTH, ssf_pkg::CFG_DATA_W'(w));
        end else begin
          set_reg(ssf_pkg::REG_FILTER_MODE, ssf_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
        end
      end
      last = (col + 1 >= eff_width(w));
      if (last) drain = (row == nrows);
      else if (row == nrows) drain = ($urandom_range(0, 9) != 0);
      else drain = ($urandom_range(0, 19) == 0);
      add_item(drain, rand_px());
      if (last) begin
        row++;
        col = 0;
      end else begin
        col++;
      end
    end while (!(last && drain));
  endtask

  initial begin
    int unsigned rand_start;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_reg(ssf_pkg::REG_FILTER_MODE, ssf_pkg::CFG_DATA_W'(ssf_pkg::MODE_SOBEL));
    set_reg(ssf_pkg::REG_IMAGE_WIDTH, 11'd0);
    add_item(CMD_PIXEL, 8'd255);
    add_item(CMD_PIXEL, 8'd0);
    add_item(CMD_DRAIN, 8'd255);
    wait_idle();
    set_reg(ssf_pkg::REG_IMAGE_WIDTH, 11'd3);
    set_reg(ssf_pkg::REG_FILTER_MODE, ssf_pkg::CFG_DATA_W'(ssf_pkg::MODE_SHARPEN));
    add_item(CMD_PIXEL, 8'd255);
    add_item(CMD_PIXEL, 8'd0);
    add_item(CMD_PIXEL, 8'd255);
    add_item(CMD_PIXEL, 8'd0);
    add_item(CMD_PIXEL, 8'd255);
    add_item(CMD_PIXEL, 8'd0);
    add_item(CMD_DRAIN, 8'd0);
    add_item(CMD_DRAIN, 8'd170);
    add_item(CMD_DRAIN, 8'd85);
    wait_idle();
    set_reg(ssf_pkg::REG_IMAGE_WIDTH, 11'd2);
    set_reg(ssf_pkg::REG_FILTER_MODE, ssf_pkg::CFG_DATA_W'(MODE_BLANK));
    add_item(CMD_DRAIN, 8'd0);
    add_item(CMD_DRAIN, 8'd0);
    add_item(CMD_PIXEL, 8'd255);
    add_item(CMD_PIXEL, 8'd128);
    add_item(CMD_DRAIN, 8'd0);
    add_item(CMD_PIXEL, 8'd7);
    add_item(CMD_PIXEL, 8'd1);
    add_item(CMD_DRAIN, 8'd0);
    wait_idle();
    set_reg(ssf_pkg::REG_FILTER_MODE, ssf_pkg::CFG_DATA_W'(MODE_BLANK_HI));
    add_item(CMD_PIXEL, 8'd0);
    add_item(CMD_PIXEL, 8'd255);
    add_item(CMD_DRAIN, 8'd0);
    add_item(CMD_DRAIN, 8'd0);
    wait_idle();

    // Widest frame: a width above the maximum acts as the maximum for the first row,
    // then the width shrinks and the frame goes on with short rows.
    steady = 1'b1;
    set_reg(ssf_pkg::REG_IMAGE_WIDTH, 11'h7FF);
    set_reg(ssf_pkg::REG_FILTER_MODE, {9'h1FF, ssf_pkg::MODE_SOBEL});
    for (int i = 0; i < LINE_LEN; i++) add_item(CMD_PIXEL, rand_px());
    wait_idle();
    set_reg(ssf_pkg::REG_IMAGE_WIDTH, 11'd8);
    for (int i = 0; i < 8; i++) add_item(CMD_PIXEL, rand_px());
    for (int i = 0; i < 8; i++) add_item(CMD_DRAIN, rand_px());
    wait_idle();

    // The receiver holds off while the sender keeps offering, so the input stalls.
    set_reg(ssf_pkg::REG_IMAGE_WIDTH, 11'd16);
    set_reg(ssf_pkg::REG_FILTER_MODE, ssf_pkg::CFG_DATA_W'(ssf_pkg::MODE_SHARPEN));
    holds_asked++;
    for (int i = 0; i < 48; i++) add_item(CMD_PIXEL, rand_px());
    for (int i = 0; i < 16; i++) add_item(CMD_DRAIN, rand_px());
    wait_idle();
    steady = 1'b0;

    rand_start = items_queued;
    while (items_queued - rand_start < RANDOM_ITEMS) random_frame();
    wait_idle();
    @(negedge clk);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ssf_pkg.sv
rtl/ssf_front.sv
rtl/ssf_queue.sv
rtl/ssf_back.sv
rtl/image_3x3_sobel_sharpen_filter.sv
sim/testbench.sv
